>>> hw/rtl/walm_pkg.sv
// walm_pkg: shared constants and types for the windowed audio level meter
// depends on nothing; imported by every walm module
`default_nettype none
package walm_pkg;
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int INTERVAL_BITS_DEF = 24;
  localparam int COUNT_BITS_DEF    = 48;
  localparam int LEVEL_BITS        = 16;
  localparam int LOG_FRAC          = 24;
  localparam int LOG_INT_BITS      = 7;
  localparam int LOG_BITS          = LOG_FRAC + LOG_INT_BITS;
  localparam int MANT_BITS         = 33;
  localparam int QUEUE_DEPTH       = 4;
  localparam logic [32:0] CENTI_K  = 33'd5050445260;
  localparam logic signed [LEVEL_BITS-1:0] LEVEL_FLOOR = -16'sd20000;
  localparam logic [14:0] FLOOR_MAG = 15'd20000;
  localparam int DEFAULT_INTERVAL = 4800;

  // back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE, ST_NORM, ST_SQUARE, ST_STEP, ST_NEXT, ST_MUL0, ST_MUL1, ST_ROUND, ST_OUT
  } lvl_state_t;
endpackage
`default_nettype wire

>>> hw/rtl/walm_front.sv
// walm_front: squares samples, keeps window and total counts, closes windows
// depends on walm_pkg
`default_nettype none
module walm_front
  import walm_pkg::*;
#(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int INTERVAL_BITS = INTERVAL_BITS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF,
  parameter int ACC_BITS      = INTERVAL_BITS + 2*SAMPLE_BITS - 1
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  input  wire signed [SAMPLE_BITS-1:0]  sample,
  input  wire [INTERVAL_BITS-1:0]       report_interval,
  output logic                          close_valid,
  output logic [ACC_BITS-1:0]           close_sum,
  output logic [INTERVAL_BITS-1:0]      close_count,
  output logic [COUNT_BITS-1:0]         close_total
);
  localparam int SQ_BITS = 2*SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0]   mag;
  logic [SQ_BITS-1:0]       sq;
  logic [ACC_BITS:0]        sum_ext;
  logic [ACC_BITS-1:0]      acc_next;
  logic [INTERVAL_BITS-1:0] win_next;
  logic [INTERVAL_BITS-1:0] interval;
  logic [COUNT_BITS-1:0]    total_count;
  logic [INTERVAL_BITS-1:0] window_count;
  logic [ACC_BITS-1:0]      power_accumulator;

  // magnitude and square; the most negative code gives 2^(N-1)
  always_comb begin
    mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    sq  = SQ_BITS'(mag) * SQ_BITS'(mag);
    sum_ext = {1'b0, power_accumulator} + (ACC_BITS+1)'(sq);
    acc_next = sum_ext[ACC_BITS] ? '1 : sum_ext[ACC_BITS-1:0];
    win_next = window_count + 1'b1;
    interval = (report_interval == '0) ? INTERVAL_BITS'(1) : report_interval;
  end

  // accumulate, count and close a window when the count reaches the interval
  always_ff @(posedge clk) begin
    if (rst) begin
      total_count       <= '0;
      window_count      <= '0;
      power_accumulator <= '0;
      close_valid       <= 1'b0;
    end else begin
      close_valid <= 1'b0;
      if (in_valid) begin
        total_count <= total_count + 1'b1;
        if (win_next >= interval) begin
          close_valid       <= 1'b1;
          window_count      <= '0;
          power_accumulator <= '0;
        end else begin
          window_count      <= win_next;
          power_accumulator <= acc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      close_sum   <= acc_next;
      close_count <= win_next;
      close_total <= total_count + 1'b1;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/walm_queue.sv
// walm_queue: small synchronous fifo; the head is read combinationally from the array
// depends on walm_pkg
`default_nettype none
module walm_queue
  import walm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire [WIDTH-1:0]  wdata,
  input  wire              pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);
  localparam int AW = $clog2(DEPTH);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr, rptr;
  logic [AW:0]      fill;
  logic             do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign empty   = (fill == '0);
  assign full    = (fill == (AW+1)'(DEPTH));
  assign rdata   = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      if (do_pop)  rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      fill <= fill + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end
endmodule
`default_nettype wire

>>> hw/rtl/walm_level.sv
// walm_level: sequential log2 difference and dB scaling of a closed window
// depends on walm_pkg
`default_nettype none
module walm_level
  import walm_pkg::*;
#(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int INTERVAL_BITS = INTERVAL_BITS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF,
  parameter int ACC_BITS      = INTERVAL_BITS + 2*SAMPLE_BITS - 1
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          job_valid,
  input  wire [ACC_BITS-1:0]           job_sum,
  input  wire [INTERVAL_BITS-1:0]      job_count,
  input  wire [COUNT_BITS-1:0]         job_total,
  output logic                         job_take,
  output logic                         res_valid,
  output logic [COUNT_BITS-1:0]        res_total,
  output logic signed [LEVEL_BITS-1:0] res_level,
  input  wire                          res_full
);
  localparam int XW = (ACC_BITS > INTERVAL_BITS) ? ACC_BITS : INTERVAL_BITS;
  localparam int EW = $clog2(XW);
  localparam logic [LOG_BITS-1:0] BIAS = LOG_BITS'(2*(SAMPLE_BITS-1)) << LOG_FRAC;

  lvl_state_t state, state_next;
  logic [XW-1:0]         x;
  logic                  second;     // working on count
  logic [31:0]           y;
  logic [63:0]           ysq;
  logic [4:0]            bit_idx;
  logic [LOG_BITS-1:0]   r, ls;
  logic [COUNT_BITS-1:0] total;
  logic [INTERVAL_BITS-1:0] cnt;
  logic [LOG_BITS-1:0]   m;
  logic [63:0]           prod_lo;
  logic [LOG_BITS+33:0]  prod;
  logic                  zero_pow;
  logic [XW-1:0]         xnorm;
  logic [EW-1:0]         top;
  logic [LOG_BITS:0]     lc;
  logic [LOG_BITS+33:0]  rounded;
  logic [15:0]           cmag;

  // top set bit, one search over the word in the normalize step
  always_comb begin
    top = '0;
    for (int i = 0; i < XW; i++)
      if (x[i]) top = EW'(i);
  end

  always_comb begin
    xnorm = (top >= EW'(31)) ? (x >> (top - EW'(31))) : (x << (EW'(31) - top));
    ysq   = 64'(y) * 64'(y);
    lc    = {1'b0, r} + {1'b0, BIAS};
    rounded = prod + ((LOG_BITS+34)'(1) << 47);
    cmag  = 16'(rounded >> 48);
  end

  // sequencer
  always_comb begin
    state_next = state;
    job_take   = 1'b0;
    unique case (state)
      ST_IDLE:   if (job_valid) begin
                   job_take = 1'b1;
                   state_next = ST_NORM;
                 end
      ST_NORM:   state_next = zero_pow ? ST_OUT : ST_SQUARE;
      ST_SQUARE: state_next = ST_STEP;
      ST_STEP:   state_next = (bit_idx == 5'd0) ? ST_NEXT : ST_SQUARE;
      ST_NEXT:   state_next = second ? ST_MUL0 : ST_NORM;
      ST_MUL0:   state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_OUT;
      ST_OUT:    if (!res_full) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign res_valid = (state == ST_OUT) && !res_full;

  // datapath: two log2 passes, then the scaled product in two halves
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cnt      <= job_count;
        total    <= job_total;
        x        <= XW'(job_sum);
        second   <= 1'b0;
        zero_pow <= (job_sum == '0) || (job_count == '0);
        res_level <= LEVEL_FLOOR;
      end
      ST_NORM: begin
        y       <= xnorm[31:0];
        r       <= LOG_BITS'(top) << LOG_FRAC;
        bit_idx <= 5'(LOG_FRAC - 1);
        res_total <= total;
      end
      // square the mantissa; a result of two or more gives a one bit and is halved
      ST_SQUARE: begin
        if (ysq[63]) begin
          r[bit_idx] <= 1'b1;
          y <= ysq[63:32];
        end else begin
          y <= ysq[62:31];
        end
      end
      ST_STEP: bit_idx <= bit_idx - 1'b1;
      ST_NEXT: begin
        if (!second) begin
          ls     <= r;
          x      <= XW'(cnt);
          second <= 1'b1;
        end else if (lc <= {1'b0, ls}) begin
          m <= '0;
        end else begin
          m <= LOG_BITS'(lc - {1'b0, ls});
        end
      end
      ST_MUL0: prod_lo <= 64'(m[15:0]) * 64'(CENTI_K);
      ST_MUL1: prod <= ((LOG_BITS+34)'(m[LOG_BITS-1:16]) * (LOG_BITS+34)'(CENTI_K) << 16)
                       + (LOG_BITS+34)'(prod_lo);
      ST_ROUND: begin
        if ((rounded >> 48) >= (LOG_BITS+34)'(FLOOR_MAG)) res_level <= LEVEL_FLOOR;
        else res_level <= -$signed(cmag);
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> hw/rtl/windowed_audio_level_meter.sv
// windowed_audio_level_meter: top level, front end, job queue, level unit, result queue
// depends on walm_pkg, walm_front, walm_queue, walm_level
//
// Usage: one signed sample per transfer on push/full. Each sample adds its
// square to the window sum. When the window count reaches report_interval
// (zero acts as one) a job goes to a five-entry job queue for the level unit.
// Input throughput is one sample per cycle, except that full is high for
// the cycle after a window closes and while the job queue is full.
// The level unit takes a new job only after the last result leaves; a zero-power
// window goes straight to output. Otherwise: two log2 passes of 24 square-and-test
// steps, each a square and a step state, plus a split multiply, rounding and output.
// A closing sample's result reaches the result ports through the front end's close
// registers, the job queue, the level unit's states and the result queue.
// Results wait in a four-entry queue read by empty/pop; when the receiver
// stalls, results pile up there and then in the job queue, and finally full rises.
// Reset clears counts, window and queues; report_interval returns to 4800.
// cfg_we writes report_interval; write it only while idle.
`default_nettype none
module windowed_audio_level_meter
  import walm_pkg::*;
#(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int INTERVAL_BITS = INTERVAL_BITS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          push,
  output logic                         full,
  input  wire signed [SAMPLE_BITS-1:0] sample,
  input  wire                          cfg_we,
  input  wire [INTERVAL_BITS-1:0]      cfg_data,
  output logic                         empty,
  input  wire                          pop,
  output logic [COUNT_BITS-1:0]        samples_read,
  output logic signed [LEVEL_BITS-1:0] level_centi_dbfs
);
  localparam int ACC_BITS = INTERVAL_BITS + 2*SAMPLE_BITS - 1;
  localparam int JOB_W = ACC_BITS + INTERVAL_BITS + COUNT_BITS;
  localparam int RES_W = COUNT_BITS + LEVEL_BITS;

  logic [INTERVAL_BITS-1:0] report_interval;
  logic close_valid, job_empty, job_full, job_take;
  logic [ACC_BITS-1:0] c_sum, j_sum;
  logic [INTERVAL_BITS-1:0] c_cnt, j_cnt;
  logic [COUNT_BITS-1:0] c_tot, j_tot, r_tot;
  logic signed [LEVEL_BITS-1:0] r_lvl;
  logic r_valid, res_full;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) report_interval <= INTERVAL_BITS'(DEFAULT_INTERVAL);
    else if (cfg_we) report_interval <= cfg_data;
  end

  // hold input while a closed window is on its way into the job queue or the job queue is full
  assign full = job_full || close_valid;

  walm_front #(.SAMPLE_BITS(SAMPLE_BITS), .INTERVAL_BITS(INTERVAL_BITS),
    .COUNT_BITS(COUNT_BITS)) u_front (
    .clk, .rst, .in_valid(push && !full), .sample, .report_interval,
    .close_valid, .close_sum(c_sum), .close_count(c_cnt), .close_total(c_tot));

  walm_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH + 1)) u_jobq (
    .clk, .rst, .push(close_valid), .wdata({c_sum, c_cnt, c_tot}),
    .pop(job_take), .rdata({j_sum, j_cnt, j_tot}), .empty(job_empty),
    .full(job_full));

  walm_level #(.SAMPLE_BITS(SAMPLE_BITS), .INTERVAL_BITS(INTERVAL_BITS),
    .COUNT_BITS(COUNT_BITS)) u_level (
    .clk, .rst, .job_valid(!job_empty), .job_sum(j_sum), .job_count(j_cnt),
    .job_total(j_tot), .job_take, .res_valid(r_valid), .res_total(r_tot),
    .res_level(r_lvl), .res_full);

  walm_queue #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_resq (
    .clk, .rst, .push(r_valid), .wdata({r_tot, r_lvl}), .pop,
    .rdata({samples_read, level_centi_dbfs}), .empty, .full(res_full));
endmodule
`default_nettype wire
